FILE: hw/rtl/lph_pkg.sv
// Shared constants and types for the linear-probing hash insert block.
// No dependencies; used by the channel interfaces and the top level.
package lph_pkg;

    localparam int TABLE_BITS_DEF = 14;
    localparam int KEY_WIDTH_DEF  = 64;

    localparam int KEY_W     = 64;
    localparam int IDX_W     = 14;
    localparam int OUTCOME_W = 2;
    localparam int TBITS_W   = 4;
    localparam int PROBES_W  = 16;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TBITS_W-1:0]  TBITS_RESET  = 4'd14;
    localparam logic [PROBES_W-1:0] PROBES_RESET = 16'd10000;

    typedef enum logic [0:0] {
        REG_TABLE_BITS = 1'b0,
        REG_MAX_PROBES = 1'b1
    } reg_idx_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_INSERTED = 2'd0,
        OUT_FOUND    = 2'd1,
        OUT_FULL     = 2'd2
    } outcome_t;

endpackage

FILE: hw/rtl/lph_key_if.sv
// Valid/ready channel that carries one key item into the block.
// Depends on lph_pkg for the key width.
interface lph_key_if;

    logic                      valid;
    logic                      ready;
    logic [lph_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);

endinterface

FILE: hw/rtl/lph_result_if.sv
// Valid/ready channel that carries one result item out of the block.
// Depends on lph_pkg for the outcome and slot index widths.
interface lph_result_if;

    logic                          valid;
    logic                          ready;
    logic [lph_pkg::OUTCOME_W-1:0] outcome;
    logic [lph_pkg::IDX_W-1:0]     slot_index;

    modport source (output valid, output outcome, output slot_index, input ready);
    modport sink (input valid, input outcome, input slot_index, output ready);

endinterface

FILE: hw/rtl/linear_probe_hash_insert.sv
// Linear-probing hash set insert: keys and occupied flags live in one synchronous
// memory of 2^TABLE_BITS entries. After reset the block sweeps the memory, one entry
// per cycle, with keys.ready low; configuration writes are taken meanwhile. An item
// is accepted in S_IDLE, then each slot probed is read in turn through the single
// read port of the slot memory, and one item is worked on at a time; the last probe
// waits while the output register is still full. A result waits in an output
// register while the next key is accepted. Depends on lph_pkg and the channel
// interfaces lph_key_if and lph_result_if.
module linear_probe_hash_insert #(
    parameter int TABLE_BITS = lph_pkg::TABLE_BITS_DEF,
    parameter int KEY_WIDTH  = lph_pkg::KEY_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lph_key_if.sink                        keys,
    lph_result_if.source                   results,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lph_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lph_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lph_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int SLOTS  = 1 << TABLE_BITS;
    localparam int ENTRY_W = KEY_WIDTH + 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CHECK = 3'b100
    } state_t;

    logic [ENTRY_W-1:0] slot_mem [SLOTS];

    state_t                              state_reg, state_next;
    logic [lph_pkg::TBITS_W-1:0]         tbits_reg;
    logic [lph_pkg::PROBES_W-1:0]        max_probes_reg;
    logic [TABLE_BITS-1:0]               clr_idx_reg, clr_idx_next;
    logic [KEY_WIDTH-1:0]                key_reg, key_next;
    logic [TABLE_BITS-1:0]               slot_reg, slot_next;
    logic [lph_pkg::PROBES_W-1:0]        left_reg, left_next;
    logic [ENTRY_W-1:0]                  rd_data_reg;
    logic                                out_valid_reg, out_valid_next;
    lph_pkg::outcome_t                   outcome_reg, outcome_next;
    logic [lph_pkg::IDX_W-1:0]           slot_index_reg, slot_index_next;

    logic [TABLE_BITS-1:0]               mask;
    logic [TABLE_BITS-1:0]               slot_inc;
    logic [lph_pkg::KEY_W-1:0]           key_in;
    logic [TABLE_BITS+lph_pkg::IDX_W-1:0] slot_wide;
    logic                                rd_en;
    logic [TABLE_BITS-1:0]               rd_addr;
    logic                                wr_en;
    logic [TABLE_BITS-1:0]               wr_addr;
    logic [ENTRY_W-1:0]                  wr_data;
    logic                                occ;
    logic                                hit;
    logic                                last_probe;
    logic                                out_free;
    logic                                cfg_wr;
    lph_pkg::reg_idx_t                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = lph_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        case (cfg_idx)
            lph_pkg::REG_TABLE_BITS: prdata = lph_pkg::APB_DATA_W'(tbits_reg);
            lph_pkg::REG_MAX_PROBES: prdata = lph_pkg::APB_DATA_W'(max_probes_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_BITS; i++)
        begin
            mask[i] = (i < int'(tbits_reg));
        end
    end

    assign key_in     = lph_pkg::KEY_W'(keys.key[KEY_WIDTH-1:0]);
    assign slot_inc   = (slot_reg + 1'b1) & mask;
    assign slot_wide  = {{lph_pkg::IDX_W{1'b0}}, slot_reg};
    assign occ        = rd_data_reg[KEY_WIDTH];
    assign hit        = (rd_data_reg[KEY_WIDTH-1:0] == key_reg);
    assign last_probe = (left_reg == lph_pkg::PROBES_W'(1));
    assign out_free   = !out_valid_reg || results.ready;

    assign keys.ready         = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.outcome    = outcome_reg;
    assign results.slot_index = slot_index_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        outcome_next    = outcome_reg;
        slot_index_next = slot_index_reg;
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = {1'b1, key_reg};

        case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (keys.valid)
                begin
                    key_next   = keys.key[KEY_WIDTH-1:0];
                    slot_next  = key_in[TABLE_BITS-1:0] & mask;
                    left_next  = (max_probes_reg == '0) ? lph_pkg::PROBES_W'(1)
                                                        : max_probes_reg;
                    rd_en      = 1'b1;
                    rd_addr    = key_in[TABLE_BITS-1:0] & mask;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (occ && !hit && !last_probe)
                begin
                    slot_next = slot_inc;
                    left_next = left_reg - 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = slot_inc;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (!occ)
                    begin
                        wr_en           = 1'b1;
                        outcome_next    = lph_pkg::OUT_INSERTED;
                        slot_index_next = slot_wide[lph_pkg::IDX_W-1:0];
                    end
                    else if (hit)
                    begin
                        outcome_next    = lph_pkg::OUT_FOUND;
                        slot_index_next = slot_wide[lph_pkg::IDX_W-1:0];
                    end
                    else
                    begin
                        outcome_next    = lph_pkg::OUT_FULL;
                        slot_index_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
            tbits_reg      <= lph_pkg::TBITS_RESET;
            max_probes_reg <= lph_pkg::PROBES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    lph_pkg::REG_TABLE_BITS: tbits_reg <= pwdata[lph_pkg::TBITS_W-1:0];
                    lph_pkg::REG_MAX_PROBES: max_probes_reg <= pwdata[lph_pkg::PROBES_W-1:0];
                    default:                 tbits_reg <= tbits_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        left_reg       <= left_next;
        outcome_reg    <= outcome_next;
        slot_index_reg <= slot_index_next;
    end

endmodule
